// ===== rtl/swmm_pkg.sv =====
// shared types and constants of the stack window min/max block
// no dependencies; imported by every module of the block
package swmm_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_QUERY = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_WINDOW = 2'd1,
		ST_FULL       = 2'd2,
		ST_EMPTY      = 2'd3
	} status_t;

	// what every cell of the chain does in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_PUSH  = 2'd1,
		CELL_SHIFT = 2'd2
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SCAN   = 2'd1,
		S_FINISH = 2'd2
	} state_t;

	// control of the running max/min unit
	typedef struct packed {
		logic take;
		logic first;
	} mm_ctl_t;

endpackage

// ===== rtl/swmm_cell.sv =====
// one storage cell of the stack chain
// depends on swmm_pkg
module swmm_cell import swmm_pkg::*; (
	input  logic                clk,
	input  cell_op_t            op,
	input  logic [DATA_W-1:0]   prev_data,
	input  logic [DATA_W-1:0]   next_data,
	output logic [DATA_W-1:0]   data
);

	logic [DATA_W-1:0] data_q;

	// push takes the entry from the cell above, shift takes the one below
	always_ff @(posedge clk) begin
		case (op)
			CELL_PUSH:  data_q <= prev_data;
			CELL_SHIFT: data_q <= next_data;
			default:    data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// ===== rtl/swmm_minmax.sv =====
// running signed maximum and minimum over a stream of samples
// depends on swmm_pkg
module swmm_minmax import swmm_pkg::*; (
	input  logic                      clk,
	input  mm_ctl_t                   ctl,
	input  logic signed [DATA_W-1:0]  sample,
	output logic signed [DATA_W-1:0]  max_value,
	output logic signed [DATA_W-1:0]  min_value
);

	logic signed [DATA_W-1:0] max_q;
	logic signed [DATA_W-1:0] min_q;

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			if (ctl.first || (sample > max_q)) begin
				max_q <= sample;
			end
			if (ctl.first || (sample < min_q)) begin
				min_q <= sample;
			end
		end
	end

	assign max_value = max_q;
	assign min_value = min_q;

endmodule

// ===== rtl/stack_window_min_max.sv =====
// Bounded stack of signed 32-bit entries with a window max/min query. The entries sit in a
// chain of DEPTH cells, top of stack in cell 0. On a push that is not refused as full, or a
// pop not refused as empty, the whole chain shifts by one cell; the result beat of a push or
// pop is loaded into the output register at once, so pushes, pops, invalid queries and
// unused modes can be taken back to back. A query with a valid window keeps the input
// closed until its result is loaded: the chain is rotated once all the way round (DEPTH
// shifts, one per cycle) while a single comparator pair watches cell 0 and folds the first
// window entries into a running max and min; the full rotation brings every entry back to
// its place, and the S_FINISH state then moves the result to the output register. The next
// item is taken only once the block is back in S_IDLE. A new input beat is taken only while
// the output register is empty or its beat leaves in the same cycle, so a stalled consumer
// stops the input, and a finished query waits in S_FINISH until the register is free.
// depends on swmm_pkg, swmm_cell, swmm_minmax
module stack_window_min_max import swmm_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 mode,
	input  logic signed [DATA_W-1:0]   value,
	input  logic [$clog2(DEPTH+1)-1:0] window,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [DATA_W-1:0]   max_value,
	output logic signed [DATA_W-1:0]   min_value,
	output logic [1:0]                 status,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// control state
	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [IDX_W-1:0]    scan_q;
	logic                out_valid_q;

	// payload registers
	logic [CNT_W-1:0]          window_q;
	logic signed [DATA_W-1:0]  max_value_q;
	logic signed [DATA_W-1:0]  min_value_q;
	logic [1:0]                status_q;
	logic [CNT_W-1:0]          count_out_q;

	// combinational controls
	logic                      in_beat;
	logic                      out_free;
	logic                      out_load;
	logic                      scan_last;
	logic                      start_scan;
	cell_op_t                  cell_op;
	mm_ctl_t                   mm_ctl;
	logic signed [DATA_W-1:0]  res_max;
	logic signed [DATA_W-1:0]  res_min;
	status_t                   res_status;
	logic signed [DATA_W-1:0]  mm_max;
	logic signed [DATA_W-1:0]  mm_min;

	// cell chain outputs
	logic [DATA_W-1:0] cell_data [DEPTH];

	// output register is free when empty or drained in this cycle
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign in_beat   = in_valid && in_ready;
	assign scan_last = (scan_q == IDX_W'(DEPTH - 1));

	// ---------------------------------------------------------------
	// chain of cells: cell 0 is the top, push comes in from above,
	// shift pulls each cell from the one below with cell 0 wrapping
	// round to the bottom so a full rotation restores the stack
	// ---------------------------------------------------------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] prev_data;
		logic [DATA_W-1:0] next_data;

		if (i == 0) begin : g_top
			assign prev_data = value;
		end else begin : g_mid
			assign prev_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_bottom
			assign next_data = cell_data[0];
		end else begin : g_above
			assign next_data = cell_data[i+1];
		end

		swmm_cell u_cell (
			.clk       (clk),
			.op        (cell_op),
			.prev_data (prev_data),
			.next_data (next_data),
			.data      (cell_data[i])
		);
	end

	// running max/min fed from the top cell during the rotation
	swmm_minmax u_minmax (
		.clk       (clk),
		.ctl       (mm_ctl),
		.sample    (cell_data[0]),
		.max_value (mm_max),
		.min_value (mm_min)
	);

	// ---------------------------------------------------------------
	// next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start_scan) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// outputs of the sequencer: cell op, count update, result beat
	// ---------------------------------------------------------------
	always_comb begin
		cell_op    = CELL_HOLD;
		count_d    = count_q;
		out_load   = 1'b0;
		start_scan = 1'b0;
		res_max    = '0;
		res_min    = '0;
		res_status = ST_OK;
		mm_ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_beat) begin
					out_load = 1'b1;
					case (mode)
						MODE_PUSH: begin
							if (count_q == CNT_W'(DEPTH)) begin
								res_status = ST_FULL;
							end else begin
								cell_op = CELL_PUSH;
								count_d = count_q + CNT_W'(1);
							end
						end
						MODE_POP: begin
							if (count_q == '0) begin
								res_status = ST_EMPTY;
							end else begin
								cell_op = CELL_SHIFT;
								count_d = count_q - CNT_W'(1);
							end
						end
						MODE_QUERY: begin
							if ((window == '0) || (window > count_q)) begin
								res_status = ST_BAD_WINDOW;
							end else begin
								// result comes after the rotation
								out_load   = 1'b0;
								start_scan = 1'b1;
							end
						end
						default: res_status = ST_OK;
					endcase
				end
			end
			S_SCAN: begin
				// one rotation step; the top cell holds original entry scan_q
				cell_op      = CELL_SHIFT;
				mm_ctl.take  = (CNT_W'(scan_q) < window_q);
				mm_ctl.first = (scan_q == '0);
			end
			S_FINISH: begin
				out_load   = out_free;
				res_max    = mm_max;
				res_min    = mm_min;
				res_status = ST_OK;
			end
			default: cell_op = CELL_HOLD;
		endcase
	end

	// ---------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == S_SCAN) begin
				scan_q <= scan_q + IDX_W'(1);
			end else begin
				scan_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// payload registers: query window and output beat
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (start_scan) begin
			window_q <= window;
		end
		if (out_load) begin
			max_value_q <= res_max;
			min_value_q <= res_min;
			status_q    <= res_status;
			count_out_q <= count_d;
		end
	end

	assign out_valid = out_valid_q;
	assign max_value = max_value_q;
	assign min_value = min_value_q;
	assign status    = status_q;
	assign count     = count_out_q;

`ifndef SYNTH
	// the stack never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// the rotation ends after exactly one pass over the chain
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && scan_last |=> (state_q == S_FINISH))
		else $error("scan did not end after a full rotation");

	// a query never changes the entry count
	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) || (state_q == S_FINISH) |=> $stable(count_q))
		else $error("entry count changed during a query");

	// no input beat is taken while the rotation of a query is in progress
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !in_ready)
		else $error("input taken during a query");
`endif

endmodule

// ===== tb/stack_window_checker.sv =====
// result checker for stack_window_min_max: predicts each result beat from accepted input beats
// depends on swmm_pkg; instantiated by testbench next to the block
module stack_window_checker import swmm_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [1:0]               mode,
	input  logic signed [DATA_W-1:0] value,
	input  logic [CNT_W-1:0]         window,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [DATA_W-1:0] max_value,
	input  logic signed [DATA_W-1:0] min_value,
	input  logic [1:0]               status,
	input  logic [CNT_W-1:0]         count,
	output int                       errors,
	output int                       pending,
	output int                       checked
);

	typedef struct packed {
		logic signed [DATA_W-1:0] hi;
		logic signed [DATA_W-1:0] lo;
		status_t                  st;
		logic [CNT_W-1:0]         level;
	} stack_beat_t;

	// shadow copy of the stack, top entry at index fill-1
	logic signed [DATA_W-1:0] entries [DEPTH];
	int                       fill;
	stack_beat_t              due [$];
	int                       n_err = 0;
	int                       n_checked = 0;

	assign errors  = n_err;
	assign pending = due.size();
	assign checked = n_checked;

	// printing stops after a couple hundred lines, counting goes on
	task automatic report_mismatch(input string msg);
		if (n_err < 200) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
		n_err++;
	endtask

	function automatic stack_beat_t apply_item(input logic [1:0] m,
			input logic signed [DATA_W-1:0] v, input logic [CNT_W-1:0] w);
		stack_beat_t b;
		b = '0;
		b.st = ST_OK;
		case (m)
			MODE_PUSH: begin
				if (fill >= DEPTH) begin
					b.st = ST_FULL;
				end else begin
					entries[fill] = v;
					fill++;
				end
			end
			MODE_POP: begin
				if (fill == 0) begin
					b.st = ST_EMPTY;
				end else begin
					fill--;
				end
			end
			MODE_QUERY: begin
				if (w == 0 || w > fill) begin
					b.st = ST_BAD_WINDOW;
				end else begin
					b.hi = entries[fill - w];
					b.lo = b.hi;
					for (int k = fill - w + 1; k < fill; k++) begin
						if (entries[k] > b.hi) b.hi = entries[k];
						if (entries[k] < b.lo) b.lo = entries[k];
					end
				end
			end
			default: ;
		endcase
		b.level = CNT_W'(fill);
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_beat_t want;
		if (!arst_n) begin
			fill = 0;
			due.delete();
		end else begin
			if (in_valid && in_ready) begin
				due.insert(due.size(), apply_item(mode, value, window));
			end
			if (out_valid && out_ready) begin
				if (due.size() == 0) begin
					report_mismatch("result beat with no item outstanding");
				end else begin
					want = due.pop_front();
					if (max_value !== want.hi)
						report_mismatch($sformatf("beat %0d max_value got %0d want %0d",
							n_checked, max_value, want.hi));
					if (min_value !== want.lo)
						report_mismatch($sformatf("beat %0d min_value got %0d want %0d",
							n_checked, min_value, want.lo));
					if (status !== want.st)
						report_mismatch($sformatf("beat %0d status got %0d want %0d",
							n_checked, status, want.st));
					if (count !== want.level)
						report_mismatch($sformatf("beat %0d count got %0d want %0d",
							n_checked, count, want.level));
					n_checked++;
				end
			end
		end
	end

endmodule

// ===== tb/testbench.sv =====
// top of the stack_window_min_max testbench: clock, reset, stimulus and verdict
// depends on swmm_pkg, stack_window_min_max and stack_window_checker
module testbench;
	import swmm_pkg::*;

	localparam int DEPTH        = 1024;
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int CLK_PERIOD   = 8;
	localparam int RANDOM_ITEMS = 580;
	// room for all the query scans of the run plus fill and unwind, with margin
	localparam int LIMIT_CYCLES = 3_000_000;
	// mode code the block leaves unused
	localparam logic [1:0] MODE_SPARE = 2'd3;
	// window that spans the whole stack
	localparam logic [CNT_W-1:0] WIN_FULL = CNT_W'(DEPTH);

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [1:0]               mode = MODE_PUSH;
	logic signed [DATA_W-1:0] value = '0;
	logic [CNT_W-1:0]         window = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] max_value;
	logic signed [DATA_W-1:0] min_value;
	logic [1:0]               status;
	logic [CNT_W-1:0]         count;

	int errors;
	int pending;
	int checked;

	// stimulus-side bookkeeping: stack level as the sender sees it, plus a few tallies
	int level = 0;
	int peak = 0;
	int n_push = 0;
	int n_full_push = 0;
	int n_pop = 0;
	int n_empty_pop = 0;
	int n_query = 0;
	int n_spare = 0;
	// no idling on either side while set
	bit calm = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	stack_window_min_max #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.window    (window),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.max_value (max_value),
		.min_value (min_value),
		.status    (status),
		.count     (count)
	);

	stack_window_checker #(.DEPTH(DEPTH)) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.window    (window),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.max_value (max_value),
		.min_value (min_value),
		.status    (status),
		.count     (count),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	// result side stalls at random, with odds of 18 in 100, unless the calm stretch is on
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 18);
	end

	// one input beat: random idle cycles first, then hold valid until accepted
	task automatic send_item(input logic [1:0] m, input logic signed [DATA_W-1:0] v,
			input logic [CNT_W-1:0] w);
		while (!calm && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		value    <= v;
		window   <= w;
		do @(posedge clk); while (!in_ready);
		// track the level so windows and targets can be aimed
		case (m)
			MODE_PUSH: begin
				n_push++;
				if (level >= DEPTH) n_full_push++;
				else level++;
			end
			MODE_POP: begin
				n_pop++;
				if (level == 0) n_empty_pop++;
				else level--;
			end
			MODE_QUERY: n_query++;
			default: n_spare++;
		endcase
		if (level > peak) peak = level;
	endtask

	// hold off the sender until every outstanding result has come back
	task automatic drain_wait();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// extremes, small values that make ties likely, and full random words
	function automatic logic signed [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 6) return 32'sh7FFF_FFFF;
		if (r < 12) return 32'sh8000_0000;
		if (r < 18) return -1;
		if (r < 22) return 0;
		if (r < 55) return $urandom_range(32) - 16;
		return $urandom();
	endfunction

	// any window from empty to the whole depth
	function automatic logic [CNT_W-1:0] any_window();
		return CNT_W'($urandom_range(DEPTH, 0));
	endfunction

	// mostly legal windows, with empty, too long and edge windows mixed in
	function automatic logic [CNT_W-1:0] pick_window();
		int r;
		r = $urandom_range(99);
		if (level == 0 || r < 8) return any_window();
		if (r < 12) return 0;
		if (r < 16) return (level < DEPTH) ? CNT_W'(level + 1) : 0;
		if (r < 28) return CNT_W'(level);
		if (r < 64) return CNT_W'($urandom_range((level < 8) ? level : 8, 1));
		return CNT_W'($urandom_range(level, 1));
	endfunction

	// stack level the random walk drifts toward for a while
	function automatic int pick_target();
		int r;
		r = $urandom_range(99);
		if (r < 15) return 0;
		if (r < 45) return $urandom_range(6, 1);
		if (r < 80) return $urandom_range(40, 7);
		return $urandom_range(200, 41);
	endfunction

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("timeout after %0d cycles, %0d results still outstanding",
			LIMIT_CYCLES, pending);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int r;
		int target;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: empty stack corner cases
		send_item(MODE_POP, 32'sh7FFF_FFFF, WIN_FULL);
		send_item(MODE_QUERY, 32'sh8000_0000, 0);
		send_item(MODE_QUERY, -1, 1);
		send_item(MODE_SPARE, 32'sh7FFF_FFFF, WIN_FULL);

		// directed: extremes and equal entries, then windows across them
		send_item(MODE_PUSH, 32'sh7FFF_FFFF, '1);
		send_item(MODE_PUSH, 32'sh8000_0000, 0);
		send_item(MODE_PUSH, -1, WIN_FULL);
		send_item(MODE_PUSH, -1, 1);
		send_item(MODE_PUSH, 0, 0);
		send_item(MODE_QUERY, 0, 1);
		send_item(MODE_QUERY, 0, 3);
		send_item(MODE_QUERY, -1, 5);
		send_item(MODE_QUERY, 0, 6);
		send_item(MODE_QUERY, 0, 0);
		send_item(MODE_QUERY, 0, WIN_FULL);
		send_item(MODE_SPARE, 32'sh8000_0000, 0);
		send_item(MODE_POP, 0, 0);
		send_item(MODE_QUERY, 0, 4);
		send_item(MODE_PUSH, 1, 2);
		send_item(MODE_QUERY, 0, 2);
		while (level > 0) send_item(MODE_POP, pick_value(), 0);
		send_item(MODE_POP, -1, WIN_FULL);

		drain_wait();

		// fill to capacity with occasional queries on the way up
		while (level < DEPTH) begin
			if ($urandom_range(63) == 0) send_item(MODE_QUERY, pick_value(), pick_window());
			else send_item(MODE_PUSH, pick_value(), any_window());
		end
		// full stack: dropped pushes, whole-stack window, pop and refill
		send_item(MODE_PUSH, 32'sh8000_0000, WIN_FULL);
		send_item(MODE_PUSH, 32'sh7FFF_FFFF, 0);
		send_item(MODE_QUERY, 0, WIN_FULL);
		send_item(MODE_QUERY, 0, 1);
		send_item(MODE_SPARE, -1, WIN_FULL);
		send_item(MODE_POP, 0, WIN_FULL);
		send_item(MODE_QUERY, 0, WIN_FULL);
		send_item(MODE_PUSH, pick_value(), 0);
		send_item(MODE_PUSH, pick_value(), WIN_FULL);
		send_item(MODE_QUERY, 0, WIN_FULL);

		// unwind back to empty, again with a few queries
		while (level > 0) begin
			if ($urandom_range(63) == 0) send_item(MODE_QUERY, pick_value(), pick_window());
			else send_item(MODE_POP, pick_value(), any_window());
		end

		drain_wait();

		// random walk toward moving targets: mostly purposeful pushes and pops,
		// about three in ten queries, and some noise and unused-mode beats
		target = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 200 && i < 320);
			if (i % 40 == 0) target = pick_target();
			if (i % 97 == 60) drain_wait();
			r = $urandom_range(99);
			if (r < 30)
				send_item(MODE_QUERY, pick_value(), pick_window());
			else if (r < 35)
				send_item(MODE_SPARE, $urandom(), any_window());
			else if (r < 43 || level == target)
				send_item($urandom_range(1) ? MODE_PUSH : MODE_POP, pick_value(),
					any_window());
			else if (level < target)
				send_item(MODE_PUSH, pick_value(), any_window());
			else
				send_item(MODE_POP, pick_value(), any_window());
		end
		calm = 1'b0;

		// let everything come back, then allow a full scan's worth of cycles for strays
		drain_wait();
		repeat (DEPTH + 16) @(posedge clk);
		@(negedge clk);

		$display("covered %0d push (%0d on a full stack), %0d pop (%0d on empty),",
			n_push, n_full_push, n_pop, n_empty_pop);
		$display("%0d query, %0d unused mode, %0d result beats compared, depth peaked at %0d of %0d",
			n_query, n_spare, checked, peak, DEPTH);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== stack_window_min_max.f =====
rtl/swmm_pkg.sv
rtl/swmm_cell.sv
rtl/swmm_minmax.sv
rtl/stack_window_min_max.sv
tb/stack_window_checker.sv
tb/testbench.sv
